// File: src/b2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types, constants and the decimal place split for the binary to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int unsigned NUM_PLACES = 5;
  localparam int unsigned IDX_W      = $clog2(NUM_PLACES);

  localparam logic [15:0] WEIGHT_10000 = 16'd10000;
  localparam logic [15:0] WEIGHT_1000  = 16'd1000;
  localparam logic [15:0] WEIGHT_100   = 16'd100;
  localparam logic [15:0] WEIGHT_10    = 16'd10;

  localparam logic [IDX_W-1:0] UNITS_IDX = IDX_W'(NUM_PLACES - 1);

  // '0' is 6'b11_0000, so a digit 0..9 fills the low four bits
  localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    digit_t        digit;
    logic [15:0]   rem;
  } split_t;

  typedef struct packed {
    logic [NUM_PLACES-1:0][3:0] digits;
    logic [IDX_W-1:0]           first;
  } dec_word_t;

  // Quotient and remainder by one decimal weight, by parallel compares
  function automatic split_t split_place(input logic [15:0] rest,
                                         input logic [15:0] weight);
    split_t      res;
    logic [19:0] mult;
    res.digit = '0;
    res.rem   = rest;
    for (int k = 1; k <= 9; k++) begin
      mult = 20'(k) * {4'b0, weight};
      if ({4'b0, rest} >= mult) begin
        res.digit = 4'(k);
        res.rem   = rest - mult[15:0];
      end
    end
    return res;
  endfunction

endpackage

// File: src/b2da_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_serializer
// Holds one converted number and sends its digits as ASCII, one per
// transfer, from the first significant digit down to the units digit.
// ----------------------------------------------------------------------------
module b2da_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_valid,
  input  b2da_pkg::dec_word_t load_word,
  output logic                load_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          out_digit_char,
  output logic                out_last
);
  import b2da_pkg::*;

  logic                       active_r, active_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [NUM_PLACES-1:0][3:0] digits_r, digits_nxt;
  logic                       at_units;
  logic                       done;

  assign at_units   = (idx_r == UNITS_IDX);
  assign done       = active_r && !out_stall && at_units;
  assign load_ready = !active_r || done;

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    digits_nxt = digits_r;
    if (active_r && !out_stall) begin
      if (at_units) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (load_valid && load_ready) begin
      active_nxt = 1'b1;
      idx_nxt    = load_word.first;
      digits_nxt = load_word.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
    digits_r <= digits_nxt;
  end

  assign out_valid      = active_r;
  assign out_digit_char = {ASCII_DIGIT_HI, digits_r[idx_r]};
  assign out_last       = at_units;

endmodule

// File: src/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned 16-bit binary to decimal ASCII text, leading zeros suppressed.
// ----------------------------------------------------------------------------
// Each accepted value passes a four-stage conversion pipeline (ten-thousands,
// thousands, hundreds, then tens and units with the first significant digit)
// and is then loaded into the output serializer, which shows its first
// character from the load on. Characters leave one per cycle while out_stall
// is low, and a value of n decimal digits (one to five) gives n characters
// on the single-character output port. The pipe can accept new values while
// the serializer is still sending an earlier one. The next value is loaded in
// the cycle its predecessor's units digit is transferred, so runs follow each
// other without a gap when a value is waiting. out_last marks the units digit.
// The block has no configuration and no state beyond the pipe and the
// serializer.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_digit_char,
  output logic        out_last
);
  import b2da_pkg::*;

  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic        s1_rdy, s2_rdy, s3_rdy, s4_rdy, ser_rdy;

  logic [3:0]  s1_d0_r;
  logic [13:0] s1_rest_r;
  logic [3:0]  s2_d0_r, s2_d1_r;
  logic [9:0]  s2_rest_r;
  logic [3:0]  s3_d0_r, s3_d1_r, s3_d2_r;
  logic [6:0]  s3_rest_r;
  dec_word_t   s4_word_r, s4_word_nxt;

  split_t      sp1, sp2, sp3, sp4;

  assign s4_rdy   = !s4_v_r || ser_rdy;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;

  assign sp1 = split_place(in_value, WEIGHT_10000);
  assign sp2 = split_place({2'b0, s1_rest_r}, WEIGHT_1000);
  assign sp3 = split_place({6'b0, s2_rest_r}, WEIGHT_100);
  assign sp4 = split_place({9'b0, s3_rest_r}, WEIGHT_10);

  always_comb begin
    s4_word_nxt.digits = {sp4.rem[3:0], sp4.digit, s3_d2_r, s3_d1_r, s3_d0_r};
    if (s3_d0_r != '0) begin
      s4_word_nxt.first = IDX_W'(0);
    end else if (s3_d1_r != '0) begin
      s4_word_nxt.first = IDX_W'(1);
    end else if (s3_d2_r != '0) begin
      s4_word_nxt.first = IDX_W'(2);
    end else if (sp4.digit != '0) begin
      s4_word_nxt.first = IDX_W'(3);
    end else begin
      s4_word_nxt.first = UNITS_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_d0_r   <= sp1.digit;
      s1_rest_r <= sp1.rem[13:0];
    end
    if (s2_rdy) begin
      s2_d0_r   <= s1_d0_r;
      s2_d1_r   <= sp2.digit;
      s2_rest_r <= sp2.rem[9:0];
    end
    if (s3_rdy) begin
      s3_d0_r   <= s2_d0_r;
      s3_d1_r   <= s2_d1_r;
      s3_d2_r   <= sp3.digit;
      s3_rest_r <= sp3.rem[6:0];
    end
    if (s4_rdy) begin
      s4_word_r <= s4_word_nxt;
    end
  end

  b2da_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_valid     (s4_v_r),
    .load_word      (s4_word_r),
    .load_ready     (ser_rdy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("run ended before the units digit");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57))
    else $error("character outside the decimal digits");

  a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !ser_rdy |=> s4_v_r && $stable(s4_word_r))
    else $error("held word lost at the serializer boundary");

endmodule
